// File: design/lca_bl_pkg.sv
// shared types and constants of the lowest common ancestor unit
package lca_bl_pkg;

  // default geometry
  localparam int unsigned NODES_DEF  = 1024;
  localparam int unsigned LEVELS_DEF = 10;

  // fixed field widths
  localparam int unsigned NODE_W  = 10;
  localparam int unsigned DEPTH_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned PATH_W  = 11;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic {
    RES_BUILD = 1'b0,
    RES_QUERY = 1'b1
  } res_kind_e;

  // one request
  typedef struct packed {
    cmd_e                 cmd;
    logic [NODE_W-1:0]    node;
    logic [NODE_W-1:0]    other_node;
    logic [NODE_W-1:0]    parent_node;
    logic                 has_parent;
    logic [DEPTH_W-1:0]   node_depth;
    logic [COUNT_W-1:0]   node_count;
  } lca_req_t;

  // one result
  typedef struct packed {
    res_kind_e            result_kind;
    logic [NODE_W-1:0]    common_ancestor;
    logic [PATH_W-1:0]    path_nodes;
  } lca_res_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CAPTURE,
    OP_B_RD_SELF,
    OP_B_RD_PAR,
    OP_B_WR,
    OP_FIN_B,
    OP_Q_RD_DEP,
    OP_Q_ORDER,
    OP_L_RD,
    OP_L_JUMP,
    OP_L_SKIP,
    OP_D_INIT,
    OP_D_RD,
    OP_D_JUMP,
    OP_P_RD,
    OP_P_SET,
    OP_LD_RD,
    OP_FIN_Q
  } dp_op_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic bld_empty;     // nothing to build
    logic node_last;     // last node of the current build level
    logic bld_lvl_last;  // last level written by the build
    logic diff_bit;      // current depth-difference bit
    logic lift_end;      // lifting finished after this step
    logic same;          // both query nodes coincide
    logic dsc_last;      // joint descent at level zero
  } dp_stat_t;

endpackage

// File: design/lca_bl_ctrl.sv
// controller state machine of the lowest common ancestor unit
module lca_bl_ctrl import lca_bl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  cmd_e     cmd_i,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o,
  output logic     busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_SELF,
    ST_B_PAR,
    ST_B_WR,
    ST_B_FIN,
    ST_Q_DEP,
    ST_Q_ORD,
    ST_Q_LIFT,
    ST_Q_LJMP,
    ST_Q_CMP,
    ST_Q_DRD,
    ST_Q_DJMP,
    ST_Q_PRD,
    ST_Q_PSET,
    ST_Q_LDEP,
    ST_Q_FIN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_i)
            CMD_LOAD: begin
              op_o = OP_LOAD;
            end
            CMD_BUILD: begin
              op_o    = OP_CAPTURE;
              state_d = ST_B_SELF;
            end
            CMD_QUERY: begin
              op_o    = OP_CAPTURE;
              state_d = ST_Q_DEP;
            end
            default: ;
          endcase
        end
      end
      ST_B_SELF: begin
        if (stat_i.bld_empty) begin
          state_d = ST_B_FIN;
        end else begin
          op_o    = OP_B_RD_SELF;
          state_d = ST_B_PAR;
        end
      end
      ST_B_PAR: begin
        op_o    = OP_B_RD_PAR;
        state_d = ST_B_WR;
      end
      ST_B_WR: begin
        op_o    = OP_B_WR;
        state_d = (stat_i.node_last && stat_i.bld_lvl_last) ? ST_B_FIN : ST_B_SELF;
      end
      ST_B_FIN: begin
        op_o    = OP_FIN_B;
        state_d = ST_IDLE;
      end
      ST_Q_DEP: begin
        op_o    = OP_Q_RD_DEP;
        state_d = ST_Q_ORD;
      end
      ST_Q_ORD: begin
        op_o    = OP_Q_ORDER;
        state_d = ST_Q_LIFT;
      end
      ST_Q_LIFT: begin
        if (stat_i.diff_bit) begin
          op_o    = OP_L_RD;
          state_d = ST_Q_LJMP;
        end else begin
          op_o    = OP_L_SKIP;
          state_d = stat_i.lift_end ? ST_Q_CMP : ST_Q_LIFT;
        end
      end
      ST_Q_LJMP: begin
        op_o    = OP_L_JUMP;
        state_d = stat_i.lift_end ? ST_Q_CMP : ST_Q_LIFT;
      end
      ST_Q_CMP: begin
        if (stat_i.same) begin
          state_d = ST_Q_LDEP;
        end else begin
          op_o    = OP_D_INIT;
          state_d = ST_Q_DRD;
        end
      end
      ST_Q_DRD: begin
        op_o    = OP_D_RD;
        state_d = ST_Q_DJMP;
      end
      ST_Q_DJMP: begin
        op_o    = OP_D_JUMP;
        state_d = stat_i.dsc_last ? ST_Q_PRD : ST_Q_DRD;
      end
      ST_Q_PRD: begin
        op_o    = OP_P_RD;
        state_d = ST_Q_PSET;
      end
      ST_Q_PSET: begin
        op_o    = OP_P_SET;
        state_d = ST_Q_LDEP;
      end
      ST_Q_LDEP: begin
        op_o    = OP_LD_RD;
        state_d = ST_Q_FIN;
      end
      ST_Q_FIN: begin
        op_o    = OP_FIN_Q;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

// File: design/lca_bl_dpath.sv
// datapath of the lowest common ancestor unit: jump table, depths, walk registers
module lca_bl_dpath import lca_bl_pkg::*; #(
  parameter int unsigned NODES  = NODES_DEF,
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lca_req_t req_i,
  input  dp_op_e   op_i,
  output dp_stat_t stat_o,
  output lca_res_t res_o,
  output logic     res_valid_o
);

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam int unsigned WW = (NW > NODE_W) ? NW : NODE_W;
  localparam int unsigned SW = DEPTH_W + 3;

  localparam logic [LW-1:0] K_TOP      = LW'(LEVELS - 1);
  localparam logic [LW-1:0] K_BLD_LAST = LW'((LEVELS > 1) ? (LEVELS - 2) : 0);

  // node index modulo NODES, restoring compare-subtract per bit
  function automatic logic [NW-1:0] wrap_node(input logic [NODE_W-1:0] x);
    int unsigned r;
    r = int'(x);
    for (int i = NODE_W - 1; i >= 0; i--) begin
      if (r >= (NODES << i)) r = r - (NODES << i);
    end
    return NW'(r);
  endfunction

  // ancestor entry: valid bit on top of the index
  logic [NW:0]         anc_mem [LEVELS][NODES];
  logic [DEPTH_W-1:0]  dep_mem [NODES];

  logic [NW:0]         rda_q, rdb_q;
  logic [DEPTH_W-1:0]  dda_q, ddb_q;

  logic [NW-1:0]       a_q, b_q, u_q, v_q, n_q;
  logic [CW-1:0]       cnt_q;
  logic [LW-1:0]       k_q;
  logic [DEPTH_W-1:0]  da_q, db_q, diff_q;

  logic                rda_ok, rdb_ok;
  logic [NW-1:0]       rda_idx, rdb_idx;

  logic [LW-1:0]       rd_lvl_a;
  logic [NW-1:0]       rd_idx_a, rd_idx_b;
  logic                anc_we;
  logic [LW-1:0]       wr_lvl;
  logic [NW-1:0]       wr_idx;
  logic [NW:0]         wr_data;
  logic [NW-1:0]       dep_rd_a;
  logic [NW-1:0]       ld_node;
  logic [CW-1:0]       cnt_clamp;

  lca_res_t            res_q;
  logic                res_valid_q;
  logic signed [SW-1:0] path_s;
  logic [PATH_W-1:0]   path_c;
  logic [WW-1:0]       lca_ext;

  assign rda_ok  = rda_q[NW];
  assign rdb_ok  = rdb_q[NW];
  assign rda_idx = rda_q[NW-1:0];
  assign rdb_idx = rdb_q[NW-1:0];
  assign ld_node = wrap_node(req_i.node);

  assign cnt_clamp = (int'(req_i.node_count) > NODES) ? CW'(NODES) : CW'(req_i.node_count);

  // read and write addresses
  always_comb begin
    rd_lvl_a = k_q;
    rd_idx_a = v_q;
    rd_idx_b = u_q;
    dep_rd_a = a_q;
    anc_we   = 1'b0;
    wr_lvl   = '0;
    wr_idx   = n_q;
    wr_data  = '0;
    case (op_i) inside
      OP_B_RD_SELF: begin
        rd_idx_a = n_q;
      end
      OP_B_RD_PAR: begin
        // own entry stays in rda_q for the write
        rd_idx_a = n_q;
        rd_idx_b = rda_idx;
      end
      OP_D_RD: begin
        rd_idx_a = u_q;
        rd_idx_b = v_q;
      end
      OP_P_RD: begin
        rd_lvl_a = '0;
        rd_idx_a = u_q;
      end
      OP_LD_RD: begin
        dep_rd_a = u_q;
      end
      OP_LOAD: begin
        anc_we  = 1'b1;
        wr_idx  = ld_node;
        wr_data = req_i.has_parent ? {1'b1, wrap_node(req_i.parent_node)} : '0;
      end
      OP_B_WR: begin
        anc_we  = 1'b1;
        wr_lvl  = k_q + LW'(1);
        wr_data = rda_ok ? rdb_q : '0;
      end
      default: ;
    endcase
  end

  // jump table and depth memories
  always_ff @(posedge clk_i) begin
    rda_q <= anc_mem[rd_lvl_a][rd_idx_a];
    rdb_q <= anc_mem[k_q][rd_idx_b];
    if (anc_we) anc_mem[wr_lvl][wr_idx] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    dda_q <= dep_mem[dep_rd_a];
    ddb_q <= dep_mem[b_q];
    if (op_i == OP_LOAD) dep_mem[ld_node] <= req_i.node_depth;
  end

  // status
  always_comb begin
    stat_o.bld_empty    = (cnt_q == '0) || (LEVELS < 2);
    stat_o.node_last    = ((CW'(n_q) + CW'(1)) == cnt_q);
    stat_o.bld_lvl_last = (k_q == K_BLD_LAST);
    stat_o.diff_bit     = diff_q[0];
    stat_o.lift_end     = (k_q == K_TOP) || (diff_q[DEPTH_W-1:1] == '0);
    stat_o.same         = (u_q == v_q);
    stat_o.dsc_last     = (k_q == '0);
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    case (op_i) inside
      OP_CAPTURE: begin
        a_q   <= wrap_node(req_i.node);
        b_q   <= wrap_node(req_i.other_node);
        cnt_q <= cnt_clamp;
        n_q   <= '0;
        k_q   <= '0;
      end
      OP_B_WR: begin
        if (stat_o.node_last) begin
          n_q <= '0;
          if (!stat_o.bld_lvl_last) k_q <= k_q + LW'(1);
        end else begin
          n_q <= n_q + NW'(1);
        end
      end
      OP_Q_ORDER: begin
        da_q <= dda_q;
        db_q <= ddb_q;
        k_q  <= '0;
        if (dda_q > ddb_q) begin
          u_q    <= b_q;
          v_q    <= a_q;
          diff_q <= dda_q - ddb_q;
        end else begin
          u_q    <= a_q;
          v_q    <= b_q;
          diff_q <= ddb_q - dda_q;
        end
      end
      OP_L_SKIP, OP_L_JUMP: begin
        if (op_i == OP_L_JUMP && rda_ok) v_q <= rda_idx;
        diff_q <= diff_q >> 1;
        if (!stat_o.lift_end) k_q <= k_q + LW'(1);
      end
      OP_D_INIT: begin
        k_q <= K_TOP;
      end
      OP_D_JUMP: begin
        if (rda_ok && rdb_ok && (rda_idx != rdb_idx)) begin
          u_q <= rda_idx;
          v_q <= rdb_idx;
        end
        if (k_q != '0) k_q <= k_q - LW'(1);
      end
      OP_P_SET: begin
        if (rda_ok) u_q <= rda_idx;
      end
      default: ;
    endcase
  end

  // path count, clamped to 1 .. 2047
  always_comb begin
    path_s = $signed({3'b000, da_q}) + $signed({3'b000, db_q})
           - $signed({2'b00, dda_q, 1'b0}) + SW'(1);
    if (path_s < $signed(SW'(1))) begin
      path_c = PATH_W'(1);
    end else if (path_s > $signed(SW'(2047))) begin
      path_c = PATH_W'(2047);
    end else begin
      path_c = path_s[PATH_W-1:0];
    end
  end

  assign lca_ext = WW'(u_q);

  always_ff @(posedge clk_i) begin
    if (op_i == OP_FIN_B) begin
      res_q.result_kind     <= RES_BUILD;
      res_q.common_ancestor <= '0;
      res_q.path_nodes      <= '0;
    end else if (op_i == OP_FIN_Q) begin
      res_q.result_kind     <= RES_QUERY;
      res_q.common_ancestor <= lca_ext[NODE_W-1:0];
      res_q.path_nodes      <= path_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (op_i == OP_FIN_B) || (op_i == OP_FIN_Q);
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// File: design/lca_binary_lifting_unit.sv
// top level of the lowest common ancestor unit (binary lifting)
//
// holds a rooted tree (or forest) of up to NODES nodes in two memories: a
// jump table of LEVELS x NODES entries (valid bit plus ancestor index) and a
// depth table of NODES entries. a request is taken when start is high and busy
// is low. a load request writes one node's parent and depth in the cycle it is
// taken; busy stays low and no result follows. a build request fills jump
// levels 1 to LEVELS-1 for the first node_count nodes (clamped to NODES), entry
// by entry: it reads the node's entry, then that ancestor's entry on the same
// level through the second read port of the jump table, then writes the next
// level; a done result follows, also when nothing is built. a query reads both
// depths, lifts the deeper node one table read per set bit of the depth
// difference, then, unless both nodes already coincide, descends them together
// from the top level with two reads per level, then steps one node up to their
// common parent, which is the answer node, and finally reads the
// depth of that node. a result is shown on res_o for exactly one cycle with
// res_valid_o high, in the first cycle with busy low again; the receiver cannot
// hold it off, so it must take it then. node indexes are taken modulo NODES.
// the tables are not cleared at reset: a node must be loaded, and a build must
// cover it, before a query touches it.
module lca_binary_lifting_unit import lca_bl_pkg::*; #(
  parameter int unsigned NODES  = NODES_DEF,
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  lca_req_t req_i,
  output lca_res_t res_o,
  output logic     res_valid_o
);

  // controller to datapath command and status
  dp_op_e   op;
  dp_stat_t stat;

  // sequencing of load, build and query walks
  lca_bl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (req_i.cmd),
    .stat_i  (stat),
    .op_o    (op),
    .busy_o  (busy)
  );

  // tables, walk registers and result register
  lca_bl_dpath #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .op_i        (op),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  // a result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  // results appear only once the walk has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result while still busy");

  // build and query requests occupy the unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.cmd == CMD_BUILD || req_i.cmd == CMD_QUERY)) |=> busy)
    else $error("build or query did not raise busy");

  // load and unused requests finish at once without a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.cmd != CMD_BUILD && req_i.cmd != CMD_QUERY)
      |=> (!busy && !res_valid_o))
    else $error("load request produced activity");

  // a query answer always counts at least one node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.result_kind == RES_QUERY) |-> (res_o.path_nodes != '0))
    else $error("empty path in query answer");

endmodule
